// ===== hdl/apsm_pkg.sv =====
package apsm_pkg;

  localparam int SAMPLE_BITS      = 12;
  localparam int SAMPLES_PER_MEAN = 32;
  localparam int MEAN_SHIFT       = $clog2(SAMPLES_PER_MEAN);
  localparam int SUM_W            = SAMPLE_BITS + MEAN_SHIFT;
  localparam int CNT_W            = MEAN_SHIFT;
  localparam int CODE_W           = 13;
  localparam int IDX_W            = 5;
  localparam int PCT_W            = 7;
  localparam int TENTH_W          = 4;
  localparam int PCT_LEN          = 26;
  localparam int PROD_W           = PCT_W + SAMPLE_BITS;
  localparam int DVD_W            = PROD_W + 3;
  localparam int DIV_CNT_W        = $clog2(DVD_W);
  localparam int REM_W            = CODE_W + 1;
  localparam int Q_W              = 10;
  localparam int DIV10_MUL        = 205;
  localparam int DIV10_SHIFT      = 11;
  localparam int QM_W             = 18;

  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);
  localparam logic [CODE_W-1:0] CODE_TOP = CODE_W'(5000);

  localparam logic [PCT_W-1:0] PCT_TABLE [PCT_LEN] = '{
    7'd0, 7'd1, 7'd3, 7'd5, 7'd10, 7'd15, 7'd20, 7'd25, 7'd30, 7'd35, 7'd40, 7'd45, 7'd50,
    7'd55, 7'd60, 7'd65, 7'd70, 7'd75, 7'd80, 7'd85, 7'd90, 7'd95, 7'd97, 7'd99, 7'd100,
    7'd100
  };

  localparam logic [CODE_W-1:0] DEF_CODES [PCT_LEN] = '{
    13'd0, 13'd49, 13'd147, 13'd246, 13'd492, 13'd737, 13'd983, 13'd1229,
    13'd1475, 13'd1720, 13'd1966, 13'd2212, 13'd2458, 13'd2703, 13'd2949, 13'd3195,
    13'd3441, 13'd3686, 13'd3932, 13'd4178, 13'd4424, 13'd4669, 13'd4768, 13'd4866,
    13'd4915, 13'd5000
  };

  typedef struct packed {
    logic                   operation;
    logic [SAMPLE_BITS-1:0] sample_code;
    logic [IDX_W-1:0]       breakpoint_index;
    logic [CODE_W-1:0]      breakpoint_code;
  } in_word_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] average_code;
    logic [PCT_W-1:0]       percent_whole;
    logic [TENTH_W-1:0]     percent_tenth;
    logic                   in_range;
  } out_word_t;

  typedef struct packed {
    logic scan_start;
    logic scan_step;
    logic mul_go;
    logic div_load;
    logic div_step;
    logic dec_go;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic group_done;
    logic scan_last;
    logic div_last;
    logic out_free;
  } ctrl_sts_t;

  function automatic logic [PCT_W-1:0] pct_at(input int unsigned k);
    logic [PCT_W-1:0] p;
    if (k < PCT_LEN) begin
      p = PCT_TABLE[k[4:0]];
    end else begin
      p = PCT_FULL;
    end
    return p;
  endfunction

  function automatic logic [CODE_W-1:0] def_code(input int unsigned k);
    logic [CODE_W-1:0] c;
    if (k < PCT_LEN) begin
      c = DEF_CODES[k[4:0]];
    end else begin
      c = CODE_TOP;
    end
    return c;
  endfunction

endpackage

// ===== hdl/apsm_ctrl.sv =====
module apsm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  apsm_pkg::ctrl_sts_t   sts,
  output apsm_pkg::ctrl_cmd_t   cmd,
  output logic                  busy
);

  import apsm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_DIV_LD,
    S_DIV,
    S_DEC,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (sts.group_done) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        state_nxt  = S_DIV_LD;
      end
      S_DIV_LD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.dec_go = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/apsm_dp.sv =====
module apsm_dp #(
  parameter int BREAKPOINT_COUNT = 26
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_accept,
  input  apsm_pkg::in_word_t    in_word,
  input  apsm_pkg::ctrl_cmd_t   cmd,
  output apsm_pkg::ctrl_sts_t   sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output apsm_pkg::out_word_t   out_word
);

  import apsm_pkg::*;

  localparam int KW = $clog2(BREAKPOINT_COUNT);

  // accumulator
  logic [SUM_W-1:0]       sum_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [SUM_W-1:0]       sum_add;
  logic [SAMPLE_BITS-1:0] mean_r;
  logic                   sample_in;
  logic                   group_end;

  assign sum_add   = sum_r + SUM_W'(in_word.sample_code);
  assign sample_in = in_accept && !in_word.operation;
  assign group_end = sample_in && (cnt_r == CNT_W'(SAMPLES_PER_MEAN - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (sample_in) begin
      if (group_end) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        sum_r <= sum_add;
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (group_end) begin
      mean_r <= sum_add[SUM_W-1 -: SAMPLE_BITS];
    end
  end

  // breakpoint table
  logic [CODE_W-1:0] bp_r [BREAKPOINT_COUNT];
  logic              bp_wr;

  assign bp_wr = in_accept && in_word.operation &&
                 (int'(in_word.breakpoint_index) < BREAKPOINT_COUNT - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BREAKPOINT_COUNT; i++) begin
        bp_r[i] <= def_code(i);
      end
    end else if (bp_wr) begin
      bp_r[KW'(in_word.breakpoint_index)] <= in_word.breakpoint_code;
    end
  end

  // segment scan, one breakpoint per cycle
  logic [KW-1:0]     k_r;
  logic [CODE_W-1:0] prev_r;
  logic [CODE_W-1:0] hi_rd;
  logic [CODE_W-1:0] mean_x;
  logic              seg_hit;
  logic [PCT_W-1:0]  p_lo;
  logic [PCT_W-1:0]  p_hi;
  logic              hit_r;
  logic [CODE_W-1:0] lo_r;
  logic [CODE_W-1:0] span_r;
  logic [PCT_W-1:0]  p0_r;
  logic [PCT_W-1:0]  dp_r;
  logic              at_lo_r;

  assign hi_rd   = bp_r[k_r];
  assign mean_x  = CODE_W'(mean_r);
  assign seg_hit = (prev_r <= mean_x) && (mean_x <= hi_rd);
  assign p_lo    = pct_at(32'(k_r) - 32'd1);
  assign p_hi    = pct_at(32'(k_r));

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      k_r    <= KW'(1);
      prev_r <= bp_r[0];
      hit_r  <= 1'b0;
    end else if (cmd.scan_step) begin
      k_r    <= k_r + KW'(1);
      prev_r <= hi_rd;
      if (seg_hit) begin
        hit_r   <= 1'b1;
        lo_r    <= prev_r;
        span_r  <= hi_rd - prev_r;
        p0_r    <= p_lo;
        dp_r    <= (p_hi >= p_lo) ? (p_hi - p_lo) : '0;
        at_lo_r <= (mean_x == prev_r);
      end
    end
  end

  // interpolation: product, bit-serial divide, split into whole and tenth
  logic [SAMPLE_BITS-1:0] diff;
  logic [PROD_W-1:0]      prod_c;
  logic [PROD_W-1:0]      prod_r;
  logic [DVD_W-1:0]       dvd_r;
  logic [REM_W-1:0]       rem_r;
  logic [DIV_CNT_W-1:0]   dcnt_r;
  logic [REM_W-1:0]       r2;
  logic                   ge;
  logic [Q_W-1:0]         quot;
  logic [QM_W-1:0]        qm_r;
  logic [PCT_W-1:0]       wq;
  logic [Q_W-1:0]         tenth_full;

  assign diff   = SAMPLE_BITS'(mean_x - lo_r);
  assign prod_c = dp_r * diff;
  assign r2     = {rem_r[REM_W-2:0], dvd_r[DVD_W-1]};
  assign ge     = (r2 >= REM_W'(span_r));
  assign quot   = at_lo_r ? '0 : dvd_r[Q_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod_r <= prod_c;
    end
    if (cmd.div_load) begin
      dvd_r  <= DVD_W'({prod_r, 3'b000}) + DVD_W'({prod_r, 1'b0});
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r  <= {dvd_r[DVD_W-2:0], ge};
      rem_r  <= ge ? (r2 - REM_W'(span_r)) : r2;
      dcnt_r <= dcnt_r + DIV_CNT_W'(1);
    end
    if (cmd.dec_go) begin
      qm_r <= QM_W'(quot * QM_W'(DIV10_MUL));
    end
  end

  assign wq         = qm_r[QM_W-1:DIV10_SHIFT];
  assign tenth_full = quot - (Q_W'({wq, 3'b000}) + Q_W'({wq, 1'b0}));

  // result word
  out_word_t out_word_r;
  logic      out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word_r.average_code  <= mean_r;
      out_word_r.in_range      <= hit_r;
      out_word_r.percent_whole <= hit_r ? (p0_r + wq) : '0;
      out_word_r.percent_tenth <= hit_r ? tenth_full[TENTH_W-1:0] : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign sts.group_done = group_end;
  assign sts.scan_last  = (k_r == KW'(BREAKPOINT_COUNT - 1));
  assign sts.div_last   = (dcnt_r == DIV_CNT_W'(DVD_W - 1));
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

// ===== hdl/averaged_piecewise_linear_sensor_map_top.sv =====
// Averages 12-bit sample words in groups of 32 and maps each mean onto a
// piecewise-linear calibration table, giving percent, one tenth digit and an
// in-range flag. Sample and breakpoint-write words are taken one per cycle
// while in_stall is low. The sample word that completes a group starts the
// mapping, and in_stall stays high while it runs: a scan that compares one
// breakpoint per cycle, a product, a bit-serial divide, then the split and
// the load of the result. The stall lasts longer if the previous result is
// still held on the output. The result sits in an output register, so input
// words are taken while it waits. Breakpoint writes to the last entry, or
// beyond it, are dropped.
module averaged_piecewise_linear_sensor_map_top #(
  parameter int BREAKPOINT_COUNT = 26
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  apsm_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output apsm_pkg::out_word_t out_word
);

  import apsm_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      busy;
  logic      in_accept;

  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;

  apsm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  apsm_dp #(
    .BREAKPOINT_COUNT (BREAKPOINT_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  a_group_starts_map: assert property (@(posedge clk) disable iff (!rst_n)
    sts.group_done |=> busy)
    else $error("completed group did not start mapping");

  a_result_after_map: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(busy))
    else $error("result word without a mapping pass");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.in_range) |->
      (out_word.percent_whole == '0 && out_word.percent_tenth == '0))
    else $error("out of range result carries a percentage");

  a_pct_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.percent_whole <= PCT_FULL &&
                   out_word.percent_tenth <= TENTH_W'(9)))
    else $error("percentage out of bounds");

endmodule

// ===== bench/averaged_piecewise_linear_sensor_map_top_tb.sv =====
`timescale 1ns / 100ps

module averaged_piecewise_linear_sensor_map_top_tb;
  import apsm_pkg::*;

  typedef enum logic {OP_SAMPLE = 1'b0, OP_WRITE = 1'b1} op_e;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCK} stall_mode_e;

  localparam int BP_COUNT     = 26;
  localparam int GROUP_LEN    = 32;
  localparam int SAMPLE_MAX   = 4095;
  localparam int CODE_MAX     = 8191;
  localparam int IDX_MAX      = 31;
  localparam int RANDOM_WORDS = 1060;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 120;

  localparam logic [6:0] PCT_STEPS [BP_COUNT] = '{
    7'd0, 7'd1, 7'd3, 7'd5, 7'd10, 7'd15, 7'd20, 7'd25, 7'd30, 7'd35, 7'd40, 7'd45, 7'd50,
    7'd55, 7'd60, 7'd65, 7'd70, 7'd75, 7'd80, 7'd85, 7'd90, 7'd95, 7'd97, 7'd99, 7'd100,
    7'd100
  };

  localparam logic [12:0] CAL_DEFAULT [BP_COUNT] = '{
    13'd0, 13'd49, 13'd147, 13'd246, 13'd492, 13'd737, 13'd983, 13'd1229,
    13'd1475, 13'd1720, 13'd1966, 13'd2212, 13'd2458, 13'd2703, 13'd2949, 13'd3195,
    13'd3441, 13'd3686, 13'd3932, 13'd4178, 13'd4424, 13'd4669, 13'd4768, 13'd4866,
    13'd4915, 13'd5000
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  logic [12:0] cal_codes [BP_COUNT];
  int unsigned group_sum;
  int unsigned group_fill;
  out_word_t   expected_maps [$];

  int errors;
  int idle_cycles;
  int burst_left;
  int stall_left;
  stall_mode_e stall_mode = STALL_NONE;
  int maps_checked;
  int maps_out_of_range;
  int maps_on_breakpoint;
  int writes_taken;
  int writes_dropped;
  int unsigned words_taken;

  averaged_piecewise_linear_sensor_map_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned step_pct(input int unsigned k);
    return (k < BP_COUNT) ? PCT_STEPS[k] : 100;
  endfunction

  task automatic map_mean(input logic [11:0] mean, output out_word_t r, output bit on_bp);
    int unsigned lo, hi, p0, p1, dp, prod;
    r = '0;
    on_bp = 1'b0;
    r.average_code = mean;
    for (int k = 1; k < BP_COUNT; k++) begin
      lo = cal_codes[k-1];
      hi = cal_codes[k];
      if (lo <= mean && mean <= hi) begin
        r.in_range = 1'b1;
        on_bp = (mean == lo) || (mean == hi);
        if (mean == lo) begin
          r.percent_whole = PCT_W'(step_pct(k - 1));
          r.percent_tenth = '0;
        end else if (mean == hi) begin
          r.percent_whole = PCT_W'(step_pct(k));
          r.percent_tenth = '0;
        end else begin
          p0 = step_pct(k - 1);
          p1 = step_pct(k);
          dp = (p1 >= p0) ? p1 - p0 : 0;
          prod = dp * (mean - lo);
          r.percent_whole = PCT_W'(p0 + prod / (hi - lo));
          r.percent_tenth = TENTH_W'((prod * 10 / (hi - lo)) % 10);
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    errors++;
    if (errors <= 30) begin
      $display("mismatch on %s after %0d results: got %0d, expected %0d",
               what, maps_checked, got, want);
    end
  endtask

  task automatic absorb_word(input in_word_t w);
    out_word_t r;
    bit on_bp;
    if (w.operation == OP_WRITE) begin
      if (w.breakpoint_index < BP_COUNT - 1) begin
        cal_codes[w.breakpoint_index] = w.breakpoint_code;
        writes_taken++;
        words_taken++;
      end else begin
        writes_dropped++;
      end
    end else begin
      words_taken++;
      group_sum += w.sample_code;
      group_fill++;
      if (group_fill == GROUP_LEN) begin
        map_mean(12'(group_sum / GROUP_LEN), r, on_bp);
        expected_maps.push_back(r);
        if (on_bp) maps_on_breakpoint++;
        if (!r.in_range) maps_out_of_range++;
        group_sum = 0;
        group_fill = 0;
      end
    end
  endtask

  task automatic check_map(input out_word_t got);
    out_word_t want;
    if (expected_maps.size() == 0) begin
      report_mismatch("result with nothing expected", got, 0);
    end else begin
      want = expected_maps.pop_front();
      maps_checked++;
      if (got.average_code !== want.average_code)
        report_mismatch("average_code", got.average_code, want.average_code);
      if (got.percent_whole !== want.percent_whole)
        report_mismatch("percent_whole", got.percent_whole, want.percent_whole);
      if (got.percent_tenth !== want.percent_tenth)
        report_mismatch("percent_tenth", got.percent_tenth, want.percent_tenth);
      if (got.in_range !== want.in_range)
        report_mismatch("in_range", got.in_range, want.in_range);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall == 1'b0) check_map(out_word);
      if (in_valid && in_stall === 1'b0) absorb_word(in_word);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("no word moved for %0d cycles", IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(8, 120);
      out_stall <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 1);
        default:     out_stall <= (stall_left > 6);
      endcase
    end
  end

  function automatic int unsigned clamp_sample(input int v);
    return (v < 0) ? 0 : ((v > SAMPLE_MAX) ? SAMPLE_MAX : v);
  endfunction

  function automatic in_word_t sample_word(input int unsigned code);
    in_word_t w;
    w = in_word_t'($urandom);
    w.operation = OP_SAMPLE;
    w.sample_code = code[11:0];
    return w;
  endfunction

  function automatic in_word_t write_word(input int unsigned idx, input int unsigned code);
    in_word_t w;
    w = in_word_t'($urandom);
    w.operation = OP_WRITE;
    w.breakpoint_index = idx[4:0];
    w.breakpoint_code = code[12:0];
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    burst_left--;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_maps.size() != 0);
  endtask

  task automatic random_write(input bit keep_order);
    int unsigned idx, lo, hi, code;
    idx = $urandom_range(0, IDX_MAX);
    code = $urandom_range(0, CODE_MAX);
    if (keep_order && idx < BP_COUNT - 1) begin
      lo = (idx == 0) ? 0 : cal_codes[idx-1];
      hi = cal_codes[idx+1];
      if (lo <= hi) code = $urandom_range(lo, hi);
    end
    send_word(write_word(idx, code));
  endtask

  task automatic restore_defaults();
    for (int k = 0; k < BP_COUNT - 1; k++) send_word(write_word(k, CAL_DEFAULT[k]));
  endtask

  // samples scatter round the target, the last one pulls the sum back onto it
  task automatic send_group(input int unsigned target, input int unsigned spread,
                            input bit mix_writes);
    int unsigned total, partial, s;
    total = GROUP_LEN * target + ((spread > 0) ? $urandom_range(0, GROUP_LEN - 1) : 0);
    partial = 0;
    for (int i = 0; i < GROUP_LEN - 1; i++) begin
      if (mix_writes && $urandom_range(0, 11) == 0) random_write(1'b1);
      s = clamp_sample(int'(target) + int'($urandom_range(0, 2 * spread)) - int'(spread));
      send_word(sample_word(s));
      partial += s;
    end
    send_word(sample_word(clamp_sample(int'(total) - int'(partial))));
  endtask

  function automatic int unsigned pick_target();
    int unsigned k, c, t;
    k = $urandom_range(0, BP_COUNT - 1);
    c = cal_codes[k];
    case ($urandom_range(0, 3))
      0: t = c;
      1: t = clamp_sample(int'(c) + int'($urandom_range(0, 6)) - 3);
      2: t = $urandom_range(0, SAMPLE_MAX);
      default: t = (c + cal_codes[(k < BP_COUNT - 1) ? k + 1 : k]) / 2;
    endcase
    return clamp_sample(int'(t));
  endfunction

  task automatic test_default_table();
    send_group(0, 0, 1'b0);
    send_group(SAMPLE_MAX, 0, 1'b0);
    send_group(1229, 0, 1'b0);
    send_group(2000, 0, 1'b0);
    wait_drained();
  endtask

  task automatic test_write_edges();
    send_word(write_word(BP_COUNT - 1, 0));
    send_word(write_word(IDX_MAX, CODE_MAX));
    send_word(write_word(BP_COUNT - 2, CODE_MAX));
    send_group(4900, 0, 1'b0);
    send_word(write_word(0, 0));
    send_group(SAMPLE_MAX, 0, 1'b1);
    restore_defaults();
    wait_drained();
  endtask

  task automatic test_no_match();
    send_word(write_word(0, CODE_MAX));
    send_group(0, 0, 1'b0);
    send_word(write_word(0, 0));
    wait_drained();
  endtask

  // a lowered breakpoint leaves one segment reversed and one very wide
  task automatic test_unsorted_table();
    send_word(write_word(10, 100));
    send_group(1000, 0, 1'b0);
    send_group(1800, 0, 1'b0);
    send_word(write_word(10, CAL_DEFAULT[10]));
    wait_drained();
  endtask

  task automatic test_group_arithmetic();
    for (int i = 0; i < GROUP_LEN - 1; i++) send_word(sample_word(SAMPLE_MAX));
    send_word(sample_word(SAMPLE_MAX - 1));
    for (int i = 0; i < GROUP_LEN; i++) send_word(sample_word((i % 2) ? SAMPLE_MAX : 0));
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned start, groups;
    start = words_taken;
    groups = 0;
    restore_defaults();
    while (words_taken - start < RANDOM_WORDS) begin
      case ($urandom_range(0, 19))
        0: restore_defaults();
        1, 2: repeat ($urandom_range(1, 6)) random_write(1'b0);
        default: begin
          send_group(pick_target(),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(100, 2000)
                                                 : $urandom_range(0, 40),
                     1'b1);
          groups++;
          if (groups % 9 == 0) wait_drained();
        end
      endcase
    end
  endtask

  initial begin
    for (int k = 0; k < BP_COUNT; k++) cal_codes[k] = CAL_DEFAULT[k];
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_table();
    test_write_edges();
    test_no_match();
    test_unsorted_table();
    test_group_arithmetic();
    test_random_traffic();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_maps.size() != 0)
      report_mismatch("results never delivered", expected_maps.size(), 0);
    $display("checked %0d mapped means: %0d outside the table, %0d on a breakpoint",
             maps_checked, maps_out_of_range, maps_on_breakpoint);
    $display("%0d breakpoint writes applied, %0d dropped for a fixed or absent entry",
             writes_taken, writes_dropped);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
